// ----- src/sorted_multi_timer_unit_core_defines.svh -----
// assertion macros shared by the timer core
`ifndef SORTED_MULTI_TIMER_UNIT_CORE_DEFINES_SVH
`define SORTED_MULTI_TIMER_UNIT_CORE_DEFINES_SVH

// a condition that holds at every clock edge out of reset
`define SMTU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// a cause that is followed by an effect in the next cycle
`define SMTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/smtu_pkg.sv -----
// types and constants of the sorted timer core
package smtu_pkg;

  localparam int TIME_W      = 32;
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = 5;

  // register indexes
  localparam logic REG_TASK_SLOT = 1'b0;
  localparam logic REG_TASK_EN   = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ALLOC   = 3'd1,
    OP_FREE    = 3'd2,
    OP_INIT    = 3'd3,
    OP_ARM     = 3'd4,
    OP_CANCEL  = 3'd5,
    OP_CAN_ALL = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    K_EXPIRY      = 3'd0,
    K_TASKSW      = 3'd1,
    K_ALLOC_OK    = 3'd2,
    K_ALLOC_FAIL  = 3'd3,
    K_CANCELLED   = 3'd4,
    K_NOT_RUNNING = 3'd5,
    K_DONE        = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    SS_FREE  = 2'd0,
    SS_ALLOC = 2'd1,
    SS_RUN   = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_FIN,
    ST_DEL,
    ST_FREE_FIN,
    ST_ARM_INS,
    ST_CAN_FIN,
    ST_AL_SCAN,
    ST_CA_RD,
    ST_CA_CHK,
    ST_CA_FREE,
    ST_CA_NEXT,
    ST_TK_CHK,
    ST_TK_RD,
    ST_TK_END
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              pop;
    logic              mark;
    logic              step;
    logic [TIME_W-1:0] new_exp;
  } cmd_t;

endpackage

// ----- src/smtu_cell.sv -----
// one list position of the sorted timer chain
module smtu_cell #(
  parameter int ID_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  smtu_pkg::cmd_t            cmd_i,
  input  logic [ID_W-1:0]           new_id_i,
  input  logic [ID_W-1:0]           del_id_i,
  input  logic                      left_before_i,
  input  logic                      left_valid_i,
  input  logic [ID_W-1:0]           left_id_i,
  input  logic [smtu_pkg::TIME_W-1:0] left_exp_i,
  input  logic                      left_tok_i,
  input  logic                      right_valid_i,
  input  logic [ID_W-1:0]           right_id_i,
  input  logic [smtu_pkg::TIME_W-1:0] right_exp_i,
  output logic                      valid_o,
  output logic [ID_W-1:0]           id_o,
  output logic [smtu_pkg::TIME_W-1:0] exp_o,
  output logic                      before_o,
  output logic                      tok_o
);

  logic                        valid_q, valid_d;
  logic                        tok_q, tok_d;
  logic [ID_W-1:0]             id_q, id_d;
  logic [smtu_pkg::TIME_W-1:0] exp_q, exp_d;

  // the new entry goes ahead of this one when it expires no later
  assign before_o = !valid_q || (cmd_i.new_exp <= exp_q);

  // insert, pop and removal wave
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    exp_d   = exp_q;
    tok_d   = tok_q;
    if (cmd_i.ins) begin
      if (left_before_i) begin
        valid_d = left_valid_i;
        id_d    = left_id_i;
        exp_d   = left_exp_i;
      end else if (before_o) begin
        valid_d = 1'b1;
        id_d    = new_id_i;
        exp_d   = cmd_i.new_exp;
      end
    end else if (cmd_i.pop) begin
      valid_d = right_valid_i;
      id_d    = right_id_i;
      exp_d   = right_exp_i;
    end else if (cmd_i.mark) begin
      tok_d = valid_q && (id_q == del_id_i);
    end else if (cmd_i.step) begin
      if (tok_q) begin
        valid_d = right_valid_i;
        id_d    = right_id_i;
        exp_d   = right_exp_i;
      end
      tok_d = left_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q  <= id_d;
    exp_q <= exp_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign exp_o   = exp_q;
  assign tok_o   = tok_q;

endmodule

// ----- src/smtu_slot_mem.sv -----
// event data and owner store, one entry per timer slot
module smtu_slot_mem #(
  parameter int NUM  = 16,
  parameter int ID_W = 4
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [ID_W-1:0] waddr_i,
  input  logic [31:0]     wdata_i,
  input  logic [7:0]      wowner_i,
  input  logic            re_i,
  input  logic [ID_W-1:0] raddr_i,
  output logic [31:0]     rdata_o,
  output logic [7:0]      rowner_o
);

  logic [31:0] data_mem  [NUM];
  logic [7:0]  owner_mem [NUM];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      data_mem[waddr_i]  <= wdata_i;
      owner_mem[waddr_i] <= wowner_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o  <= data_mem[raddr_i];
      rowner_o <= owner_mem[raddr_i];
    end
  end

endmodule

// ----- src/sorted_multi_timer_unit_core.sv -----
// sorted timer list core: chain of list cells, slot store and op sequencer
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  one op word: opcode, slot, delay, data, owner
//  m_*       out  m_tvalid/m_tready  result words, m_tlast on the final one of an op
//  apb       in   psel/penable       task timer slot and enable registers
//
// one op at a time; alloc scans the slots one per cycle and cancel all scans them in turn,
// removal from the list is a wave through the cell chain, insert shifts the chain cells
// in place, and a tick pops each expired slot from the head of the list.
// reset empties the list and frees every slot at once.
// a stalled result word holds the sequencer, the next op word is taken as soon as
// the previous op has handed its last word to the output register.
`include "sorted_multi_timer_unit_core_defines.svh"

module sorted_multi_timer_unit_core #(
  parameter int NUM_TIMERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[3:0], delay[35:4], event_data[67:36], owner[75:68], auto_cancel[76]
  input  logic [79:0] s_tdata,
  // opcode[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_slot[3:0], result_owner[11:4], result_data[43:12]
  output logic [47:0] m_tdata,
  // kind[2:0]
  output logic [2:0]  m_tuser,
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ID_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TW   = smtu_pkg::TIME_W;
  localparam int CW   = smtu_pkg::CNT_W;

  // configuration registers
  logic [3:0] task_slot_q;
  logic       task_en_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_slot_q <= '0;
      task_en_q   <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == smtu_pkg::REG_TASK_SLOT) begin
        task_slot_q <= pwdata[3:0];
      end else begin
        task_en_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == smtu_pkg::REG_TASK_SLOT) begin
      prdata = {28'd0, task_slot_q};
    end else begin
      prdata = {31'd0, task_en_q};
    end
  end

  // sequencer registers
  smtu_pkg::state_e state_q, state_d, ret_q, ret_d;
  smtu_pkg::op_e    op_q;
  smtu_pkg::kind_e  r_kind_q, r_kind_d;
  logic [3:0]       r_slot_q, r_slot_d;
  logic [3:0]       slot_q;
  logic [ID_W-1:0]  idx_q, idx_d;
  logic [ID_W-1:0]  del_cnt_q, del_cnt_d;
  logic             ok_q;
  logic [TW-1:0]    delay_q;
  logic [31:0]      in_data_q;
  logic [7:0]       in_owner_q;
  logic             in_ac_q;
  logic [TW-1:0]    tick_q, tick_d;
  logic [CW-1:0]    k_q, k_d;
  logic             ts_q, ts_d;
  logic             pend_v_q, pend_v_d, pend_load;
  logic [3:0]       pend_slot_q, rd_slot_q, rd_slot_d;
  logic [7:0]       pend_owner_q;
  logic [31:0]      pend_data_q;

  // slot status and auto-cancel flags
  smtu_pkg::status_e status_q [NUM_TIMERS];
  logic              ac_q     [NUM_TIMERS];
  logic              st_we, ac_we, ac_wval;
  logic [ID_W-1:0]   st_waddr;
  smtu_pkg::status_e st_wval, st_rd;
  logic              ac_rd;

  assign st_rd = status_q[idx_q];
  assign ac_rd = ac_q[idx_q];

  // output register
  logic          out_v_q;
  logic [2:0]    out_kind_q;
  logic [3:0]    out_slot_q;
  logic [7:0]    out_owner_q;
  logic [31:0]   out_data_q;
  logic          out_last_q;
  logic          out_free;
  logic          emit;
  smtu_pkg::kind_e e_kind;
  logic [3:0]    e_slot;
  logic [7:0]    e_owner;
  logic [31:0]   e_data;
  logic          e_last;

  assign out_free = !out_v_q || m_tready;

  // memory ports
  logic            mem_we, mem_re;
  logic [ID_W-1:0] mem_raddr;
  logic [31:0]     mem_rdata;
  logic [7:0]      mem_rowner;

  // cell chain
  smtu_pkg::cmd_t  cmd;
  logic [NUM_TIMERS-1:0] valid_w, before_w, tok_w;
  logic [ID_W-1:0] id_w  [NUM_TIMERS];
  logic [TW-1:0]   exp_w [NUM_TIMERS];

  genvar gi;
  generate
    for (gi = 0; gi < NUM_TIMERS; gi++) begin : g_cell
      logic            l_before, l_valid, l_tok, r_valid;
      logic [ID_W-1:0] l_id, r_id;
      logic [TW-1:0]   l_exp, r_exp;
      if (gi == 0) begin : g_first
        assign l_before = 1'b0;
        assign l_valid  = 1'b0;
        assign l_tok    = 1'b0;
        assign l_id     = '0;
        assign l_exp    = '0;
      end else begin : g_mid
        assign l_before = before_w[gi-1];
        assign l_valid  = valid_w[gi-1];
        assign l_tok    = tok_w[gi-1];
        assign l_id     = id_w[gi-1];
        assign l_exp    = exp_w[gi-1];
      end
      if (gi == NUM_TIMERS - 1) begin : g_last
        assign r_valid = 1'b0;
        assign r_id    = '0;
        assign r_exp   = '0;
      end else begin : g_inner
        assign r_valid = valid_w[gi+1];
        assign r_id    = id_w[gi+1];
        assign r_exp   = exp_w[gi+1];
      end
      smtu_cell #(.ID_W(ID_W)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .cmd_i         (cmd),
        .new_id_i      (idx_q),
        .del_id_i      (idx_q),
        .left_before_i (l_before),
        .left_valid_i  (l_valid),
        .left_id_i     (l_id),
        .left_exp_i    (l_exp),
        .left_tok_i    (l_tok),
        .right_valid_i (r_valid),
        .right_id_i    (r_id),
        .right_exp_i   (r_exp),
        .valid_o       (valid_w[gi]),
        .id_o          (id_w[gi]),
        .exp_o         (exp_w[gi]),
        .before_o      (before_w[gi]),
        .tok_o         (tok_w[gi])
      );
    end
  endgenerate

  smtu_slot_mem #(.NUM(NUM_TIMERS), .ID_W(ID_W)) u_mem (
    .clk_i    (clk_i),
    .we_i     (mem_we),
    .waddr_i  (idx_q),
    .wdata_i  (in_data_q),
    .wowner_i (in_owner_q),
    .re_i     (mem_re),
    .raddr_i  (mem_raddr),
    .rdata_o  (mem_rdata),
    .rowner_o (mem_rowner)
  );

  // head of list checks for a tick
  logic head_due, head_task, idx_last, del_last;
  assign head_due  = valid_w[0] && (exp_w[0] <= tick_q) &&
                     ((k_q + CW'(ts_q)) < CW'(smtu_pkg::MAX_RESULTS));
  assign head_task = task_en_q && (32'(id_w[0]) == 32'(task_slot_q));
  assign idx_last  = (32'(idx_q) == 32'(NUM_TIMERS - 1));
  assign del_last  = (32'(del_cnt_q) == 32'(NUM_TIMERS - 1));
  assign s_tready  = (state_q == smtu_pkg::ST_IDLE);

  // next state and sequencer outputs
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    r_kind_d  = r_kind_q;
    r_slot_d  = r_slot_q;
    idx_d     = idx_q;
    del_cnt_d = del_cnt_q;
    tick_d    = tick_q;
    k_d       = k_q;
    ts_d      = ts_q;
    pend_v_d  = pend_v_q;
    pend_load = 1'b0;
    rd_slot_d = rd_slot_q;
    cmd       = '0;
    cmd.new_exp = tick_q + delay_q;
    st_we     = 1'b0;
    st_waddr  = idx_q;
    st_wval   = smtu_pkg::SS_FREE;
    ac_we     = 1'b0;
    ac_wval   = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx_q;
    emit      = 1'b0;
    e_kind    = r_kind_q;
    e_slot    = r_slot_q;
    e_owner   = '0;
    e_data    = '0;
    e_last    = 1'b1;
    case (state_q)
      smtu_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          idx_d   = ID_W'(s_tdata[3:0]);
          state_d = smtu_pkg::ST_DEC;
        end
      end
      smtu_pkg::ST_DEC: begin
        r_kind_d = smtu_pkg::K_DONE;
        r_slot_d = slot_q;
        state_d  = smtu_pkg::ST_FIN;
        case (op_q)
          smtu_pkg::OP_TICK: begin
            tick_d  = tick_q + TW'(1);
            k_d     = '0;
            ts_d    = 1'b0;
            state_d = smtu_pkg::ST_TK_CHK;
          end
          smtu_pkg::OP_ALLOC: begin
            idx_d   = '0;
            state_d = smtu_pkg::ST_AL_SCAN;
          end
          smtu_pkg::OP_FREE: begin
            if (ok_q && st_rd == smtu_pkg::SS_RUN) begin
              cmd.mark  = 1'b1;
              del_cnt_d = '0;
              ret_d     = smtu_pkg::ST_FREE_FIN;
              state_d   = smtu_pkg::ST_DEL;
            end else if (ok_q) begin
              state_d = smtu_pkg::ST_FREE_FIN;
            end
          end
          smtu_pkg::OP_INIT: begin
            if (ok_q) begin
              mem_we  = 1'b1;
              ac_we   = 1'b1;
              ac_wval = in_ac_q;
            end
          end
          smtu_pkg::OP_ARM: begin
            if (ok_q && st_rd == smtu_pkg::SS_RUN) begin
              cmd.mark  = 1'b1;
              del_cnt_d = '0;
              ret_d     = smtu_pkg::ST_ARM_INS;
              state_d   = smtu_pkg::ST_DEL;
            end else if (ok_q && st_rd != smtu_pkg::SS_FREE) begin
              state_d = smtu_pkg::ST_ARM_INS;
            end
          end
          smtu_pkg::OP_CANCEL: begin
            if (ok_q && st_rd == smtu_pkg::SS_RUN) begin
              cmd.mark  = 1'b1;
              del_cnt_d = '0;
              ret_d     = smtu_pkg::ST_CAN_FIN;
              state_d   = smtu_pkg::ST_DEL;
            end else begin
              r_kind_d = smtu_pkg::K_NOT_RUNNING;
            end
          end
          smtu_pkg::OP_CAN_ALL: begin
            r_slot_d = '0;
            idx_d    = '0;
            state_d  = smtu_pkg::ST_CA_RD;
          end
          default: begin
          end
        endcase
      end
      smtu_pkg::ST_DEL: begin
        cmd.step  = 1'b1;
        del_cnt_d = del_cnt_q + ID_W'(1);
        if (del_last) begin
          state_d = ret_q;
        end
      end
      smtu_pkg::ST_FREE_FIN: begin
        st_we   = 1'b1;
        st_wval = smtu_pkg::SS_FREE;
        state_d = smtu_pkg::ST_FIN;
      end
      smtu_pkg::ST_ARM_INS: begin
        cmd.ins = 1'b1;
        st_we   = 1'b1;
        st_wval = smtu_pkg::SS_RUN;
        state_d = smtu_pkg::ST_FIN;
      end
      smtu_pkg::ST_CAN_FIN: begin
        st_we    = 1'b1;
        st_wval  = smtu_pkg::SS_ALLOC;
        r_kind_d = smtu_pkg::K_CANCELLED;
        state_d  = smtu_pkg::ST_FIN;
      end
      smtu_pkg::ST_AL_SCAN: begin
        if (st_rd == smtu_pkg::SS_FREE) begin
          st_we    = 1'b1;
          st_wval  = smtu_pkg::SS_ALLOC;
          ac_we    = 1'b1;
          ac_wval  = 1'b0;
          r_kind_d = smtu_pkg::K_ALLOC_OK;
          r_slot_d = 4'(idx_q);
          state_d  = smtu_pkg::ST_FIN;
        end else if (idx_last) begin
          r_kind_d = smtu_pkg::K_ALLOC_FAIL;
          r_slot_d = '0;
          state_d  = smtu_pkg::ST_FIN;
        end else begin
          idx_d = idx_q + ID_W'(1);
        end
      end
      smtu_pkg::ST_CA_RD: begin
        mem_re  = 1'b1;
        state_d = smtu_pkg::ST_CA_CHK;
      end
      smtu_pkg::ST_CA_CHK: begin
        state_d = smtu_pkg::ST_CA_NEXT;
        if (st_rd != smtu_pkg::SS_FREE && ac_rd && mem_rowner == in_owner_q) begin
          if (st_rd == smtu_pkg::SS_RUN) begin
            cmd.mark  = 1'b1;
            del_cnt_d = '0;
            ret_d     = smtu_pkg::ST_CA_FREE;
            state_d   = smtu_pkg::ST_DEL;
          end else begin
            state_d = smtu_pkg::ST_CA_FREE;
          end
        end
      end
      smtu_pkg::ST_CA_FREE: begin
        st_we   = 1'b1;
        st_wval = smtu_pkg::SS_FREE;
        state_d = smtu_pkg::ST_CA_NEXT;
      end
      smtu_pkg::ST_CA_NEXT: begin
        if (idx_last) begin
          state_d = smtu_pkg::ST_FIN;
        end else begin
          idx_d   = idx_q + ID_W'(1);
          state_d = smtu_pkg::ST_CA_RD;
        end
      end
      smtu_pkg::ST_FIN: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = smtu_pkg::ST_IDLE;
        end
      end
      smtu_pkg::ST_TK_CHK: begin
        mem_raddr = id_w[0];
        if (head_due) begin
          cmd.pop  = 1'b1;
          st_we    = 1'b1;
          st_waddr = id_w[0];
          st_wval  = smtu_pkg::SS_ALLOC;
          if (head_task) begin
            ts_d = 1'b1;
          end else begin
            mem_re    = 1'b1;
            rd_slot_d = 4'(id_w[0]);
            k_d       = k_q + CW'(1);
            state_d   = smtu_pkg::ST_TK_RD;
          end
        end else begin
          state_d = smtu_pkg::ST_TK_END;
        end
      end
      smtu_pkg::ST_TK_RD: begin
        e_kind  = smtu_pkg::K_EXPIRY;
        e_slot  = pend_slot_q;
        e_owner = pend_owner_q;
        e_data  = pend_data_q;
        e_last  = 1'b0;
        if (!pend_v_q || out_free) begin
          emit      = pend_v_q;
          pend_load = 1'b1;
          pend_v_d  = 1'b1;
          state_d   = smtu_pkg::ST_TK_CHK;
        end
      end
      smtu_pkg::ST_TK_END: begin
        if (pend_v_q) begin
          e_kind  = smtu_pkg::K_EXPIRY;
          e_slot  = pend_slot_q;
          e_owner = pend_owner_q;
          e_data  = pend_data_q;
          e_last  = !ts_q;
          if (out_free) begin
            emit     = 1'b1;
            pend_v_d = 1'b0;
          end
        end else if (ts_q) begin
          e_kind = smtu_pkg::K_TASKSW;
          e_slot = task_slot_q;
          if (out_free) begin
            emit = 1'b1;
            ts_d = 1'b0;
          end
        end else begin
          state_d = smtu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = smtu_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= smtu_pkg::ST_IDLE;
      ret_q    <= smtu_pkg::ST_IDLE;
      tick_q   <= '0;
      ts_q     <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        status_q[i] <= smtu_pkg::SS_FREE;
        ac_q[i]     <= 1'b0;
      end
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      tick_q   <= tick_d;
      ts_q     <= ts_d;
      pend_v_q <= pend_v_d;
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (m_tready) begin
        out_v_q <= 1'b0;
      end
      if (st_we) begin
        status_q[st_waddr] <= st_wval;
      end
      if (ac_we) begin
        ac_q[idx_q] <= ac_wval;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    del_cnt_q <= del_cnt_d;
    r_kind_q  <= r_kind_d;
    r_slot_q  <= r_slot_d;
    k_q       <= k_d;
    rd_slot_q <= rd_slot_d;
    if (s_tready && s_tvalid) begin
      op_q       <= smtu_pkg::op_e'(s_tuser);
      slot_q     <= s_tdata[3:0];
      ok_q       <= (32'(s_tdata[3:0]) < 32'(NUM_TIMERS));
      delay_q    <= s_tdata[35:4];
      in_data_q  <= s_tdata[67:36];
      in_owner_q <= s_tdata[75:68];
      in_ac_q    <= s_tdata[76];
    end
    if (pend_load) begin
      pend_slot_q  <= rd_slot_q;
      pend_owner_q <= mem_rowner;
      pend_data_q  <= mem_rdata;
    end
    if (emit) begin
      out_kind_q  <= e_kind;
      out_slot_q  <= e_slot;
      out_owner_q <= e_owner;
      out_data_q  <= e_data;
      out_last_q  <= e_last;
    end
  end

  assign m_tvalid = out_v_q;
  assign m_tuser  = out_kind_q;
  assign m_tdata  = {4'd0, out_data_q, out_owner_q, out_slot_q};
  assign m_tlast  = out_last_q;

  // checks on the chain and the sequencer
  `SMTU_ASSERT_ALWAYS(a_tok_single, $onehot0(tok_w), "more than one removal token in chain")
  `SMTU_ASSERT_ALWAYS(a_chain_packed, (valid_w & (valid_w + {{(NUM_TIMERS-1){1'b0}}, 1'b1})) == '0, "gap in timer chain")
  `SMTU_ASSERT_NEXT(a_del_done, state_q == smtu_pkg::ST_DEL && del_last, tok_w == '0, "removal wave did not leave chain")
  `SMTU_ASSERT_NEXT(a_fin_exit, state_q == smtu_pkg::ST_FIN && out_free, state_q == smtu_pkg::ST_IDLE, "final word sent but op not closed")

endmodule
